// File: hw/rtl/pcrl_pkg.sv
// Shared constants and controller/datapath interface types for the rate limiter.
package pcrl_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int TIME_BITS     = 32;
	localparam int CHANNEL_BITS  = 8;

	localparam int CHANNEL_ID_WIDTH   = 8;
	localparam int NOW_TICKS_WIDTH    = 32;
	localparam int MIN_INTERVAL_WIDTH = 16;

	localparam int IDX_BITS  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int USED_BITS = $clog2(TABLE_ENTRIES + 1);
	localparam int CMP_BITS  = (TIME_BITS > MIN_INTERVAL_WIDTH) ? TIME_BITS : MIN_INTERVAL_WIDTH;

	localparam logic [MIN_INTERVAL_WIDTH-1:0] MIN_INTERVAL_RESET = MIN_INTERVAL_WIDTH'(60);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted item
		logic lookup;  // search the table and register the hit
		logic commit;  // decide, update the table and load the result register
	} pcrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // result register is empty or is being taken this cycle
	} pcrl_status_t;

endpackage

// File: hw/rtl/pcrl_ctrl.sv
// Controller state machine that sequences capture, lookup and commit of each item.
module pcrl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pcrl_pkg::pcrl_status_t status,
	output pcrl_pkg::pcrl_cmd_t    cmd
);
	import pcrl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_DECIDE
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	always_comb begin
		cmd.load   = in_valid && !in_stall_q;
		cmd.lookup = (state_q == S_LOOKUP);
		cmd.commit = (state_q == S_DECIDE) && status.out_free;
	end

	assign in_stall = in_stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q    <= S_LOOKUP;
						in_stall_q <= 1'b1;
					end
				end
				S_LOOKUP: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (cmd.commit) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

	a_stall_tracks_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) == !in_stall_q)
		else $error("input stall disagrees with controller state");

	a_load_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_LOOKUP)
		else $error("accepted item did not start a lookup");

	a_lookup_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOKUP |=> state_q == S_DECIDE)
		else $error("lookup not followed by decision");

endmodule

// File: hw/rtl/pcrl_datapath.sv
// Datapath: channel table, interval register, elapsed-time compare and result register.
module pcrl_datapath (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  pcrl_pkg::pcrl_cmd_t                        cmd,
	output pcrl_pkg::pcrl_status_t                     status,
	input  logic                                       cfg_write,
	input  logic [pcrl_pkg::MIN_INTERVAL_WIDTH-1:0]    cfg_data,
	input  logic [pcrl_pkg::CHANNEL_ID_WIDTH-1:0]      channel_id,
	input  logic [pcrl_pkg::NOW_TICKS_WIDTH-1:0]       now_ticks,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic                                       blocked,
	output logic                                       new_entry,
	output logic                                       table_full
);
	import pcrl_pkg::*;

	logic [MIN_INTERVAL_WIDTH-1:0] min_interval_q;

	logic [CHANNEL_BITS-1:0] entry_channel_q [TABLE_ENTRIES];
	logic [TIME_BITS-1:0]    entry_time_q    [TABLE_ENTRIES];
	logic [USED_BITS-1:0]    used_q;

	logic [CHANNEL_BITS-1:0] chan_s1;
	logic [TIME_BITS-1:0]    now_s1;

	logic                 found_s2;
	logic [IDX_BITS-1:0]  idx_s2;
	logic [TIME_BITS-1:0] last_s2;

	logic out_valid_q, blocked_q, new_entry_q, table_full_q;

	logic                 hit_found;
	logic [IDX_BITS-1:0]  hit_idx;
	logic [TIME_BITS-1:0] elapsed;
	logic                 too_soon;
	logic                 room;

	// First matching valid entry wins, lowest index first.
	always_comb begin
		hit_found = 1'b0;
		hit_idx   = '0;
		for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
			if ((USED_BITS'(k) < used_q) && (entry_channel_q[k] == chan_s1)) begin
				hit_found = 1'b1;
				hit_idx   = IDX_BITS'(k);
			end
		end
	end

	assign elapsed  = now_s1 - last_s2;
	assign too_soon = CMP_BITS'(elapsed) < CMP_BITS'(min_interval_q);
	assign room     = used_q < USED_BITS'(TABLE_ENTRIES);

	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= MIN_INTERVAL_RESET;
			used_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				min_interval_q <= cfg_data;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (!found_s2 && room) begin
					used_q <= used_q + USED_BITS'(1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			chan_s1 <= CHANNEL_BITS'(channel_id);
			now_s1  <= TIME_BITS'(now_ticks);
		end
		if (cmd.lookup) begin
			found_s2 <= hit_found;
			idx_s2   <= hit_idx;
			last_s2  <= entry_time_q[hit_idx];
		end
		if (cmd.commit) begin
			if (found_s2) begin
				blocked_q    <= too_soon;
				new_entry_q  <= 1'b0;
				table_full_q <= 1'b0;
				if (!too_soon) begin
					entry_time_q[idx_s2] <= now_s1;
				end
			end else begin
				blocked_q    <= 1'b0;
				new_entry_q  <= room;
				table_full_q <= !room;
				if (room) begin
					entry_channel_q[used_q[IDX_BITS-1:0]] <= chan_s1;
					entry_time_q[used_q[IDX_BITS-1:0]]    <= now_s1;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign blocked    = blocked_q;
	assign new_entry  = new_entry_q;
	assign table_full = table_full_q;

	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_BITS'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(new_entry_q && table_full_q) && !(blocked_q && new_entry_q)
			&& !(blocked_q && table_full_q))
		else $error("result flags not mutually exclusive");

	a_new_entry_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !found_s2 && room |=> used_q == $past(used_q) + USED_BITS'(1))
		else $error("new channel not counted");

endmodule

// File: hw/rtl/per_channel_rate_limiter_top.sv
// Top level of the per-channel rate limiter: controller, datapath and configuration port.
//
// The block enforces a minimum interval, in ticks, between the allowed requests of each
// channel. Each item names a channel and gives the current wrapping tick count; the block
// answers with exactly one result item carrying blocked, new_entry and table_full. A table
// of eight channels is held in flip-flops and searched in parallel, the first matching
// entry winning. An unknown channel is recorded and allowed; when the table is full it is
// allowed but not recorded and table_full is set. Elapsed time is the wrapping difference
// of the tick counts, so a time that appears to go backwards counts as a long wait, and an
// interval of zero never blocks. An item is captured at the edge that accepts it; the table
// search is then registered in the lookup state, and the decide state, which waits for a free
// result register, does the subtract-and-compare against min_interval and the table update.
// The input is stalled from acceptance until the result is loaded, so a new item is never
// taken while one is in flight; a result still held by a stalled receiver delays the loading
// of the next one. The result sits in an output register, so the next item is accepted
// while a finished result still waits. The table needs no clearing after reset: only
// entries below the fill count are ever compared. min_interval resets to 60 and is written
// through the configuration channel, which is always ready; write it only while no item is
// in flight.
module per_channel_rate_limiter_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [pcrl_pkg::MIN_INTERVAL_WIDTH-1:0] cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [pcrl_pkg::CHANNEL_ID_WIDTH-1:0]   channel_id,
	input  logic [pcrl_pkg::NOW_TICKS_WIDTH-1:0]    now_ticks,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    blocked,
	output logic                                    new_entry,
	output logic                                    table_full
);
	import pcrl_pkg::*;

	pcrl_cmd_t    cmd;
	pcrl_status_t status;

	// The interval register can always take a write.
	assign cfg_ready = 1'b1;

	pcrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pcrl_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_write  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.channel_id (channel_id),
		.now_ticks  (now_ticks),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.blocked    (blocked),
		.new_entry  (new_entry),
		.table_full (table_full)
	);

endmodule

// File: tb/per_channel_rate_limiter_top_tb.sv
// Self-checking testbench for the per-channel rate limiter: directed script, then random traffic.
module per_channel_rate_limiter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcrl_pkg::*;

	// A watchdog ends the run if nothing at all is accepted for this many cycles. The slowest
	// correct gap between two acceptances is a sender gap, the pipeline and a receiver stall,
	// or a drain pause between phases.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 155;
	localparam int PHASE_COUNT    = 6;

	// One verdict, as carried by a result item.
	typedef struct packed {
		logic blocked;
		logic new_entry;
		logic table_full;
	} verdict_t;

	// A row of the directed script is either a request item or a write of min_interval.
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                      kind;
		logic [MIN_INTERVAL_WIDTH-1:0]  cfg_value;
		logic [CHANNEL_ID_WIDTH-1:0]    chan;
		logic [NOW_TICKS_WIDTH-1:0]     ticks;
		logic                           typed;   // verdict typed in rather than predicted
		verdict_t                       verdict;
	} script_row_t;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           cfg_valid  = 1'b0;
	logic                           cfg_ready;
	logic [MIN_INTERVAL_WIDTH-1:0]  cfg_data   = '0;
	logic                           in_valid   = 1'b0;
	logic                           in_stall;
	logic [CHANNEL_ID_WIDTH-1:0]    channel_id = '0;
	logic [NOW_TICKS_WIDTH-1:0]     now_ticks  = '0;
	logic                           out_valid;
	logic                           out_stall  = 1'b0;
	logic                           blocked;
	logic                           new_entry;
	logic                           table_full;

	// Shadow of the limiter: the interval in force and the channels recorded so far, in the
	// order in which they were first seen, each with the time of its last allowed request.
	logic [MIN_INTERVAL_WIDTH-1:0]  interval_setting = MIN_INTERVAL_RESET;
	logic [CHANNEL_ID_WIDTH-1:0]    seen_chan [TABLE_ENTRIES];
	logic [NOW_TICKS_WIDTH-1:0]     seen_time [TABLE_ENTRIES];
	int                             seen_count = 0;

	verdict_t     pending_verdicts [$];
	script_row_t  script_rows [$];
	int           failures    = 0;
	bit           calm        = 1'b0;   // when set, neither side idles nor stalls
	int           sink_hold   = 0;
	int           idle_cycles = 0;

	per_channel_rate_limiter_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.channel_id (channel_id),
		.now_ticks  (now_ticks),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.blocked    (blocked),
		.new_entry  (new_entry),
		.table_full (table_full)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Works out the verdict for one accepted request and updates the shadow table the same
	// way the block does. The first matching entry wins; the elapsed time is the wrapping
	// difference of the tick counts, compared against the zero-extended interval.
	function automatic verdict_t judge_request(input logic [CHANNEL_ID_WIDTH-1:0] chan,
			input logic [NOW_TICKS_WIDTH-1:0] ticks);
		verdict_t                    v;
		int                          hit;
		int                          k;
		logic [NOW_TICKS_WIDTH-1:0]  elapsed;
		v = '0;
		hit = -1;
		for (k = 0; k < seen_count; k++) begin
			if (hit < 0 && seen_chan[k] == chan)
				hit = k;
		end
		if (hit < 0) begin
			if (seen_count < TABLE_ENTRIES) begin
				seen_chan[seen_count] = chan;
				seen_time[seen_count] = ticks;
				seen_count++;
				v.new_entry = 1'b1;
			end else begin
				// A newcomer at a full table is let through but never remembered.
				v.table_full = 1'b1;
			end
		end else begin
			elapsed = ticks - seen_time[hit];
			if (elapsed < NOW_TICKS_WIDTH'(interval_setting))
				v.blocked = 1'b1;
			else
				seen_time[hit] = ticks;
		end
		return v;
	endfunction

	task automatic add_row(input row_kind_t kind, input logic [MIN_INTERVAL_WIDTH-1:0] cfg_value,
			input logic [CHANNEL_ID_WIDTH-1:0] chan, input logic [NOW_TICKS_WIDTH-1:0] ticks,
			input logic typed, input logic b, input logic n, input logic f);
		script_row_t r;
		r.kind      = kind;
		r.cfg_value = cfg_value;
		r.chan      = chan;
		r.ticks     = ticks;
		r.typed     = typed;
		r.verdict   = {b, n, f};
		script_rows.push_back(r);
	endtask

	// Presents one request after a random gap, waits for the block to take it, and files
	// its verdict: the typed-in one where given, otherwise the predicted one. The shadow
	// table is advanced in both cases. Valid is left high so that a back-to-back request
	// never sees it lowered and raised within one time step.
	task automatic send_request(input logic [CHANNEL_ID_WIDTH-1:0] chan,
			input logic [NOW_TICKS_WIDTH-1:0] ticks, input logic typed, input verdict_t typed_v);
		int        gap;
		verdict_t  predicted;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		channel_id <= chan;
		now_ticks  <= ticks;
		do @(posedge clk); while (in_stall);
		predicted = judge_request(chan, ticks);
		pending_verdicts.push_back(typed ? typed_v : predicted);
	endtask

	// Holds the sender back until every outstanding verdict has come out, then lets the
	// pipeline settle before anything else happens.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_interval(input logic [MIN_INTERVAL_WIDTH-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		interval_setting = value;
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
			failures++;
		end
	endtask

	// Result side: every item taken is compared with the oldest verdict on file. After each
	// one the receiver draws how many cycles to stall before it will take the next.
	always @(posedge clk) begin : result_sink
		verdict_t want;
		if (out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result item with none expected, actual b=%b n=%b f=%b",
					$time, blocked, new_entry, table_full);
				failures++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("blocked", want.blocked, blocked);
				check_field("new_entry", want.new_entry, new_entry);
				check_field("table_full", want.table_full, table_full);
			end
			sink_hold = calm ? 0 : $urandom_range(0, 11);
			out_stall <= (sink_hold != 0);
		end else if (sink_hold != 0) begin
			sink_hold--;
			if (sink_hold == 0)
				out_stall <= 1'b0;
		end
	end

	// Watchdog: a run in which nothing moves on any channel for too long has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : stimulus
		script_row_t                    r;
		verdict_t                       none;
		logic [MIN_INTERVAL_WIDTH-1:0]  phase_interval [PHASE_COUNT];
		logic [CHANNEL_ID_WIDTH-1:0]    chan;
		logic [NOW_TICKS_WIDTH-1:0]     ticks;
		int                             k;
		int                             pick;

		none = '0;

		// Directed script. It starts under the reset interval of 60 ticks.
		// A first request from a channel records it; one tick short of the interval is refused;
		// exactly the interval is allowed.
		add_row(ROW_ITEM, '0, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0);
		add_row(ROW_ITEM, '0, 8'h00, 32'h0000_003B, 1'b1, 1'b1, 1'b0, 1'b0);
		add_row(ROW_ITEM, '0, 8'h00, 32'h0000_003C, 1'b1, 1'b0, 1'b0, 1'b0);
		// Top channel recorded at the very top of the tick range; the count then wraps, so 59
		// ticks later is refused and 60 ticks later is allowed.
		add_row(ROW_ITEM, '0, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0);
		add_row(ROW_ITEM, '0, 8'hFF, 32'h0000_003A, 1'b1, 1'b1, 1'b0, 1'b0);
		add_row(ROW_ITEM, '0, 8'hFF, 32'h0000_003B, 1'b1, 1'b0, 1'b0, 1'b0);
		// A time that goes backwards reads as a very long wait and is allowed.
		add_row(ROW_ITEM, '0, 8'h00, 32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0);
		// With a zero interval even a repeat at the same tick goes through.
		add_row(ROW_CFG, 16'h0000, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_row(ROW_ITEM, '0, 8'h00, 32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0);
		// Largest interval: one tick short is refused, the full interval is allowed.
		add_row(ROW_CFG, 16'hFFFF, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_row(ROW_ITEM, '0, 8'h55, 32'h1234_5678, 1'b1, 1'b0, 1'b1, 1'b0);
		add_row(ROW_ITEM, '0, 8'h55, 32'h1235_5676, 1'b1, 1'b1, 1'b0, 1'b0);
		add_row(ROW_ITEM, '0, 8'h55, 32'h1235_5677, 1'b1, 1'b0, 1'b0, 1'b0);
		add_row(ROW_ITEM, '0, 8'h00, 32'h0001_0010, 1'b0, 1'b0, 1'b0, 1'b0);
		// Fill the remaining entries of the table.
		add_row(ROW_ITEM, '0, 8'hAA, 32'h8000_0000, 1'b1, 1'b0, 1'b1, 1'b0);
		add_row(ROW_ITEM, '0, 8'h0F, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0);
		add_row(ROW_ITEM, '0, 8'hF0, 32'h0F0F_0F0F, 1'b1, 1'b0, 1'b1, 1'b0);
		add_row(ROW_ITEM, '0, 8'h33, 32'h3333_0000, 1'b1, 1'b0, 1'b1, 1'b0);
		add_row(ROW_ITEM, '0, 8'hCC, 32'hCCCC_CCCC, 1'b1, 1'b0, 1'b1, 1'b0);
		// A newcomer at a full table is allowed without being recorded, every time it comes;
		// the last recorded entry still matches.
		add_row(ROW_ITEM, '0, 8'h01, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 1'b1);
		add_row(ROW_ITEM, '0, 8'hCC, 32'hCCCC_CCCC, 1'b1, 1'b1, 1'b0, 1'b0);
		add_row(ROW_ITEM, '0, 8'h01, 32'h0000_0002, 1'b1, 1'b0, 1'b0, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script_rows[i]) begin
			r = script_rows[i];
			if (r.kind == ROW_CFG)
				write_interval(r.cfg_value);
			else
				send_request(r.chan, r.ticks, r.typed, r.verdict);
		end

		// Random traffic, one interval per phase, the extremes among them. The table is full by now,
		// so most requests come from recorded channels, mostly with times aimed around the end of the
		// interval, else spread over twice it, arbitrary or earlier; the rest are unknown channels.
		phase_interval[0] = 16'd1;
		phase_interval[1] = 16'($urandom_range(2, 200));
		phase_interval[2] = 16'd60;
		phase_interval[3] = 16'd0;
		phase_interval[4] = 16'hFFFF;
		phase_interval[5] = 16'($urandom_range(0, 65535));

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_interval(phase_interval[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// Now and then the sender waits for every verdict before going on.
				if ($urandom_range(0, 49) == 0)
					wait_drained();
				if ($urandom_range(0, 99) < 15 || seen_count == 0) begin
					chan  = CHANNEL_ID_WIDTH'($urandom);
					ticks = $urandom;
				end else begin
					k     = $urandom_range(0, seen_count - 1);
					chan  = seen_chan[k];
					pick  = $urandom_range(0, 9);
					if (pick <= 5)
						ticks = seen_time[k] + NOW_TICKS_WIDTH'(interval_setting)
							+ NOW_TICKS_WIDTH'($urandom_range(0, 6)) - 32'd3;
					else if (pick <= 7)
						ticks = seen_time[k] + NOW_TICKS_WIDTH'($urandom_range(0,
							2 * int'(interval_setting) + 1));
					else if (pick == 8)
						ticks = $urandom;
					else
						ticks = seen_time[k] - NOW_TICKS_WIDTH'($urandom_range(1, 1000));
				end
				send_request(chan, ticks, 1'b0, none);
			end
		end

		calm = 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
